// ----- hw/rtl/fmf_pkg.sv -----
package fmf_pkg;

  // capacity of one message in bytes
  localparam int unsigned MAX_MESSAGE_BYTES = 65536;

  // byte counter holds every value up to the capacity itself
  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

  // body length accumulator before the range check
  localparam int unsigned ACC_W = CNT_W + 4;

  // fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 17;

  // ascii characters of the frame tags
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_1     = 8'h31;
  localparam logic [BYTE_W-1:0] CHAR_8     = 8'h38;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_EQUAL = 8'h3d;

  // reset value of the delimiter register (SOH)
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h01;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_BUSY    = 2'd0,
    STATUS_READY   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // per-byte result from the frame tracker
  typedef struct packed {
    status_e            status;
    logic [LEN_W-1:0]   length;
  } result_t;

endpackage

// ----- hw/rtl/fmf_in_reg.sv -----
module fmf_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [fmf_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [fmf_pkg::BYTE_W-1:0] data_o
);
  import fmf_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] data_q;
  logic              load;

  // hold a request only while the next stage cannot move
  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/fmf_frame_fsm.sv -----
module fmf_frame_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [fmf_pkg::BYTE_W-1:0] data_i,
  input  logic [fmf_pkg::BYTE_W-1:0] delimiter_i,
  output fmf_pkg::result_t           result_o
);
  import fmf_pkg::*;

  localparam logic [3:0] PH_BEGIN_TAG  = 4'd0;
  localparam logic [3:0] PH_BEGIN_VAL  = 4'd1;
  localparam logic [3:0] PH_LEN_TAG    = 4'd2;
  localparam logic [3:0] PH_LEN_DIGITS = 4'd3;
  localparam logic [3:0] PH_LEN_BAD    = 4'd4;
  localparam logic [3:0] PH_BODY       = 4'd5;
  localparam logic [3:0] PH_SUM_TAG    = 4'd6;
  localparam logic [3:0] PH_SUM_VAL    = 4'd7;

  logic [3:0]        phase_q, phase_d;
  logic [1:0]        tag_pos_q, tag_pos_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [CNT_W-1:0]  body_len_q, body_len_d;
  logic [CNT_W-1:0]  body_rem_q, body_rem_d;
  logic [BYTE_W-1:0] first_q, first_d;

  logic [CNT_W-1:0]  seen_inc;
  logic [ACC_W-1:0]  acc_base;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  rem_dec;
  logic              is_delim;
  logic              digit_hit;
  logic              is_eq;
  status_e           status;
  logic [LEN_W-1:0]  length;

  assign seen_inc  = seen_q + CNT_W'(1);
  assign is_delim  = (data_i == delimiter_i);
  assign digit_hit = (data_i >= CHAR_0) && (data_i <= CHAR_9);
  assign is_eq     = (data_i == CHAR_EQUAL);

  // decimal accumulate: length * 10 + digit
  assign acc_base = ACC_W'(body_len_q);
  assign acc      = (acc_base << 3) + (acc_base << 1) + ACC_W'(data_i[3:0]);
  assign rem_dec  = (body_rem_q != '0) ? body_rem_q - CNT_W'(1) : body_rem_q;

  // frame tracking for one byte
  always_comb begin
    phase_d    = phase_q;
    tag_pos_d  = tag_pos_q;
    seen_d     = seen_inc;
    body_len_d = body_len_q;
    body_rem_d = body_rem_q;
    first_d    = first_q;
    status     = STATUS_BUSY;
    length     = '0;

    case (phase_q)
      PH_BEGIN_TAG, PH_LEN_TAG: begin
        if (tag_pos_q == 2'd0) begin
          first_d   = data_i;
          tag_pos_d = 2'd1;
        end else if (is_eq && (first_q == ((phase_q == PH_BEGIN_TAG) ? CHAR_8 : CHAR_9))) begin
          phase_d    = (phase_q == PH_BEGIN_TAG) ? PH_BEGIN_VAL : PH_LEN_DIGITS;
          tag_pos_d  = 2'd0;
          body_len_d = '0;
        end else begin
          status = STATUS_INVALID;
        end
      end
      PH_BEGIN_VAL: begin
        if (is_delim) begin
          phase_d   = PH_LEN_TAG;
          tag_pos_d = 2'd0;
        end
      end
      PH_LEN_DIGITS: begin
        if (is_delim) begin
          if (tag_pos_q == 2'd0) begin
            status = STATUS_INVALID;
          end else if (body_len_q == '0) begin
            phase_d   = PH_SUM_TAG;
            tag_pos_d = 2'd0;
            first_d   = '0;
          end else begin
            body_rem_d = body_len_q;
            phase_d    = PH_BODY;
          end
        end else if (digit_hit) begin
          tag_pos_d = 2'd1;
          if (acc > ACC_W'(MAX_MESSAGE_BYTES)) begin
            phase_d = PH_LEN_BAD;
          end else begin
            body_len_d = acc[CNT_W-1:0];
          end
        end else begin
          phase_d = PH_LEN_BAD;
        end
      end
      PH_LEN_BAD: begin
        if (is_delim) begin
          status = STATUS_INVALID;
        end
      end
      PH_BODY: begin
        body_rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d   = PH_SUM_TAG;
          tag_pos_d = 2'd0;
          first_d   = '0;
        end
      end
      PH_SUM_TAG: begin
        if (tag_pos_q == 2'd0) begin
          first_d   = data_i;
          tag_pos_d = 2'd1;
        end else if (tag_pos_q == 2'd1) begin
          // keep only a match flag for the two tag digits
          first_d   = ((first_q == CHAR_1) && (data_i == CHAR_0)) ? 8'd1 : 8'd0;
          tag_pos_d = 2'd2;
        end else if ((first_q == 8'd1) && is_eq) begin
          phase_d   = PH_SUM_VAL;
          tag_pos_d = 2'd0;
        end else begin
          status = STATUS_INVALID;
        end
      end
      PH_SUM_VAL: begin
        if (is_delim) begin
          status = STATUS_READY;
          length = LEN_W'(seen_inc);
        end
      end
      default: begin
        status = STATUS_INVALID;
      end
    endcase

    // message at capacity and not finished on this byte
    if ((status == STATUS_BUSY) && (seen_inc >= CNT_W'(MAX_MESSAGE_BYTES))) begin
      status = STATUS_INVALID;
    end

    // resync to the start of a frame after any verdict
    if (status != STATUS_BUSY) begin
      phase_d    = PH_BEGIN_TAG;
      tag_pos_d  = 2'd0;
      seen_d     = '0;
      body_len_d = '0;
      body_rem_d = '0;
      first_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_BEGIN_TAG;
      tag_pos_q  <= 2'd0;
      seen_q     <= '0;
      body_len_q <= '0;
      body_rem_q <= '0;
      first_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tag_pos_q  <= tag_pos_d;
      seen_q     <= seen_d;
      body_len_q <= body_len_d;
      body_rem_q <= body_rem_d;
      first_q    <= first_d;
    end
  end

  assign result_o.status = status;
  assign result_o.length = length;

endmodule

// ----- hw/rtl/fix_message_framer.sv -----
// FIX message framer, one status result for every received byte.
//
// Input channel: data_byte_i with in_valid_i / in_stall_o. A byte is taken
// on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: status_o and message_length_o with out_valid_o /
// out_stall_i. status_o is 0 while a frame is in progress, 1 when the
// checksum delimiter closes a message (message_length_o then holds the
// total byte count), 2 when the frame is invalid.
// Delimiter register: delimiter_we_i writes delimiter_i on the next edge.
//
// Path: a byte accepted into the input register passes the frame tracker
// and is written into the result register once that register is free or
// being drained. Throughput is one byte per cycle while out_stall_i does
// not hold a result.
// When out_stall_i holds a result, a byte can still be taken while the input
// register is empty, after which in_stall_o rises until the result is taken.
// Reset empties both registers, returns the tracker to the start of a
// frame and sets the delimiter to SOH.
module fix_message_framer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [fmf_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       delimiter_we_i,
  input  logic [fmf_pkg::BYTE_W-1:0] delimiter_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fmf_pkg::STATUS_W-1:0] status_o,
  output logic [fmf_pkg::LEN_W-1:0]  message_length_o
);
  import fmf_pkg::*;

  logic              advance;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic [BYTE_W-1:0] delim_q;
  result_t           result;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  // result register free or being drained this cycle
  assign advance = ~out_valid_q | ~out_stall_i;

  fmf_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .valid_o     (byte_valid),
    .data_o      (byte_data)
  );

  fmf_frame_fsm u_frame_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance & byte_valid),
    .data_i      (byte_data),
    .delimiter_i (delim_q),
    .result_o    (result)
  );

  // delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (delimiter_we_i) begin
      delim_q <= delimiter_i;
    end
  end

  // result register
  assign out_valid_d = advance ? byte_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && byte_valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign message_length_o = out_q.length;

endmodule

// ----- tb/tb_fix_message_framer.sv -----
module tb_fix_message_framer;
  import fmf_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 4;

  // framer phases of the predictor
  typedef enum logic [3:0] {
    FR_BEGIN_TAG,
    FR_BEGIN_VAL,
    FR_LEN_TAG,
    FR_LEN_DIGITS,
    FR_LEN_BAD,
    FR_BODY,
    FR_SUM_TAG,
    FR_SUM_VAL
  } frame_phase_e;

  // ways a generated message can be broken
  typedef enum int {
    DEF_NONE,
    DEF_BEGIN_TAG,
    DEF_LEN_TAG,
    DEF_LEN_EMPTY,
    DEF_LEN_ALPHA,
    DEF_LEN_HUGE,
    DEF_SUM_TAG,
    DEF_TRUNCATE,
    DEF_NOISE
  } defect_e;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] data_byte_i    = '0;
  logic              delimiter_we_i = 1'b0;
  logic [BYTE_W-1:0] delimiter_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [LEN_W-1:0]  message_length_o;

  fix_message_framer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .delimiter_we_i   (delimiter_we_i),
    .delimiter_i      (delimiter_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .message_length_o (message_length_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [BYTE_W-1:0] cur_delim;
  frame_phase_e      fr_phase;
  logic [1:0]        fr_tag_pos;
  logic [CNT_W-1:0]  fr_seen;
  logic [CNT_W-1:0]  fr_body_len;
  logic [CNT_W-1:0]  fr_body_left;
  logic [BYTE_W-1:0] fr_first;

  result_t pending_results[$];
  result_t head_r;

  int unsigned bytes_sent     = 0;
  int unsigned checked_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned ready_count    = 0;
  int unsigned invalid_count  = 0;
  int unsigned delim_settings = 0;

  bit          idle_on      = 1'b1;
  bit          long_hold_en = 1'b0;
  int unsigned hold_cnt     = 0;
  int unsigned stall_left   = 0;

  task automatic frame_restart();
    fr_phase     = FR_BEGIN_TAG;
    fr_tag_pos   = '0;
    fr_seen      = '0;
    fr_body_len  = '0;
    fr_body_left = '0;
    fr_first     = '0;
  endtask

  task automatic frame_to_checksum();
    fr_phase   = FR_SUM_TAG;
    fr_tag_pos = '0;
    fr_first   = '0;
  endtask

  // next status of the framer for one received byte
  task automatic track_byte(input logic [BYTE_W-1:0] b, output result_t r);
    status_e          st;
    logic [LEN_W-1:0] len;
    logic [ACC_W-1:0] acc;
    logic [BYTE_W-1:0] want;
    st  = STATUS_BUSY;
    len = '0;
    fr_seen = fr_seen + 1'b1;
    case (fr_phase)
      FR_BEGIN_TAG, FR_LEN_TAG: begin
        if (fr_tag_pos == 2'd0) begin
          fr_first   = b;
          fr_tag_pos = 2'd1;
        end else begin
          want = (fr_phase == FR_BEGIN_TAG) ? CHAR_8 : CHAR_9;
          if (fr_first == want && b == CHAR_EQUAL) begin
            if (fr_phase == FR_BEGIN_TAG) fr_phase = FR_BEGIN_VAL;
            else fr_phase = FR_LEN_DIGITS;
            fr_tag_pos  = 2'd0;
            fr_body_len = '0;
          end else begin
            st = STATUS_INVALID;
          end
        end
      end
      FR_BEGIN_VAL: begin
        if (b == cur_delim) begin
          fr_phase   = FR_LEN_TAG;
          fr_tag_pos = 2'd0;
        end
      end
      FR_LEN_DIGITS: begin
        // delimiter test comes before the digit test
        if (b == cur_delim) begin
          if (fr_tag_pos == 2'd0) begin
            st = STATUS_INVALID;
          end else if (fr_body_len == 0) begin
            frame_to_checksum();
          end else begin
            fr_body_left = fr_body_len;
            fr_phase     = FR_BODY;
          end
        end else if (b >= CHAR_0 && b <= CHAR_9) begin
          acc = ACC_W'(fr_body_len * 10 + (b - CHAR_0));
          fr_tag_pos = 2'd1;
          if (acc > MAX_MESSAGE_BYTES) fr_phase = FR_LEN_BAD;
          else fr_body_len = acc[CNT_W-1:0];
        end else begin
          fr_phase = FR_LEN_BAD;
        end
      end
      FR_LEN_BAD: begin
        if (b == cur_delim) st = STATUS_INVALID;
      end
      FR_BODY: begin
        if (fr_body_left > 0) fr_body_left = fr_body_left - 1'b1;
        if (fr_body_left == 0) frame_to_checksum();
      end
      FR_SUM_TAG: begin
        if (fr_tag_pos == 2'd0) begin
          fr_first   = b;
          fr_tag_pos = 2'd1;
        end else if (fr_tag_pos == 2'd1) begin
          fr_first   = (fr_first == CHAR_1 && b == CHAR_0) ? 8'd1 : 8'd0;
          fr_tag_pos = 2'd2;
        end else begin
          if (fr_first == 8'd1 && b == CHAR_EQUAL) begin
            fr_phase   = FR_SUM_VAL;
            fr_tag_pos = 2'd0;
          end else begin
            st = STATUS_INVALID;
          end
        end
      end
      FR_SUM_VAL: begin
        if (b == cur_delim) begin
          st  = STATUS_READY;
          len = fr_seen;
        end
      end
      default: begin
        st = STATUS_INVALID;
      end
    endcase
    // capacity reached without a complete message
    if (st == STATUS_BUSY && fr_seen >= MAX_MESSAGE_BYTES) st = STATUS_INVALID;
    if (st != STATUS_BUSY) frame_restart();
    r.status = st;
    r.length = len;
  endtask

  // receiver: random stall bursts and one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!long_hold_en) hold_cnt <= 0;
      if (long_hold_en && hold_cnt < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt + 1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 6);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d length %0d", status_o, message_length_o);
      end else begin
        head_r = pending_results.pop_front();
        if (head_r.status == STATUS_READY) ready_count++;
        else if (head_r.status == STATUS_INVALID) invalid_count++;
        if (status_o !== head_r.status || message_length_o !== head_r.length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected status %0d length %0d, got status %0d length %0d",
                     checked_count, head_r.status, head_r.length, status_o, message_length_o);
        end
        checked_count++;
      end
    end
  end

  // one byte request, valid stays high after acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    track_byte(b, r);
    pending_results.push_back(r);
    bytes_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and let every result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [BYTE_W-1:0] v);
    @(posedge clk_i);
    delimiter_we_i <= 1'b1;
    delimiter_i    <= v;
    @(posedge clk_i);
    delimiter_we_i <= 1'b0;
    cur_delim = v;
    delim_settings++;
  endtask

  function automatic logic [BYTE_W-1:0] free_byte();
    logic [BYTE_W-1:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == cur_delim);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == avoid);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] non_digit_byte();
    logic [BYTE_W-1:0] v;
    do v = 8'($urandom_range(0, 255));
    while ((v >= CHAR_0 && v <= CHAR_9) || v == cur_delim);
    return v;
  endfunction

  // build one message, possibly broken, and send it
  task automatic send_message(input int body_len, input defect_e defect);
    logic [BYTE_W-1:0] frame[$];
    string digits;
    int bad_pos;
    int alpha_pos;
    int keep;
    if (defect == DEF_NOISE) begin
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      // begin tag and value
      bad_pos = $urandom_range(0, 2);
      frame.push_back((defect == DEF_BEGIN_TAG && bad_pos != 1) ? other_byte(CHAR_8) : CHAR_8);
      frame.push_back((defect == DEF_BEGIN_TAG && bad_pos != 0) ?
                      other_byte(CHAR_EQUAL) : CHAR_EQUAL);
      repeat ($urandom_range(0, 6)) frame.push_back(free_byte());
      frame.push_back(cur_delim);
      // body length tag and digits
      frame.push_back((defect == DEF_LEN_TAG && bad_pos != 1) ? other_byte(CHAR_9) : CHAR_9);
      frame.push_back((defect == DEF_LEN_TAG && bad_pos != 0) ?
                      other_byte(CHAR_EQUAL) : CHAR_EQUAL);
      if (defect == DEF_LEN_HUGE) begin
        digits = $sformatf("%0d", $urandom_range(MAX_MESSAGE_BYTES + 1, 9999999));
      end else if (defect == DEF_LEN_EMPTY) begin
        digits = "";
      end else begin
        digits = $sformatf("%0d", body_len);
        if ($urandom_range(0, 4) == 0) digits = {"00", digits};
      end
      alpha_pos = $urandom_range(0, digits.len());
      for (int i = 0; i <= digits.len(); i++) begin
        if (defect == DEF_LEN_ALPHA && i == alpha_pos) frame.push_back(non_digit_byte());
        if (i < digits.len()) frame.push_back(digits[i]);
      end
      frame.push_back(cur_delim);
      if (defect != DEF_LEN_HUGE && defect != DEF_LEN_EMPTY && defect != DEF_LEN_ALPHA) begin
        // body bytes may hold any value, the delimiter too
        repeat (body_len) frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back((defect == DEF_SUM_TAG && bad_pos == 0) ? other_byte(CHAR_1) : CHAR_1);
        frame.push_back((defect == DEF_SUM_TAG && bad_pos == 1) ? other_byte(CHAR_0) : CHAR_0);
        frame.push_back((defect == DEF_SUM_TAG && bad_pos == 2) ?
                        other_byte(CHAR_EQUAL) : CHAR_EQUAL);
        repeat ($urandom_range(0, 3)) frame.push_back(free_byte());
        frame.push_back(cur_delim);
      end
      if (defect == DEF_TRUNCATE) begin
        keep = $urandom_range(1, frame.size() - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
    end
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  function automatic int pick_body_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(21, 300);
    return $urandom_range(0, 20);
  endfunction

  function automatic defect_e pick_defect();
    if ($urandom_range(0, 99) < 75) return DEF_NONE;
    return defect_e'($urandom_range(DEF_BEGIN_TAG, DEF_NOISE));
  endfunction

  // short messages with empty fields, a bad tag, an empty length, byte extremes
  task automatic test_directed();
    logic [BYTE_W-1:0] seq[$];
    seq = {CHAR_8, CHAR_EQUAL, DELIM_RESET, CHAR_9, CHAR_EQUAL, CHAR_0, DELIM_RESET,
           CHAR_1, CHAR_0, CHAR_EQUAL, DELIM_RESET,
           8'h37, CHAR_EQUAL,
           CHAR_8, CHAR_EQUAL, 8'hff, DELIM_RESET, CHAR_9, CHAR_EQUAL, DELIM_RESET,
           CHAR_8, CHAR_EQUAL, DELIM_RESET, CHAR_9, CHAR_EQUAL, CHAR_1, DELIM_RESET,
           8'h00, CHAR_1, CHAR_0, CHAR_EQUAL, DELIM_RESET};
    foreach (seq[i]) send_byte(seq[i]);
    drain();
  endtask

  // extreme delimiters, a digit, '=' and '8' as delimiter
  task automatic test_delimiter_values();
    logic [BYTE_W-1:0] delims[$];
    delims = {8'h00, 8'hff, CHAR_0 + 8'd5, CHAR_EQUAL, CHAR_8, DELIM_RESET};
    foreach (delims[i]) begin
      drain();
      write_delimiter(delims[i]);
      send_message($urandom_range(0, 12), pick_defect());
      send_message($urandom_range(0, 12), DEF_NONE);
    end
    drain();
  endtask

  // delimiter changed halfway through a message
  task automatic test_write_mid_message();
    logic [BYTE_W-1:0] head[$];
    logic [BYTE_W-1:0] tail[$];
    head = {CHAR_8, CHAR_EQUAL, 8'h41};
    tail = {DELIM_RESET, 8'h7c, CHAR_9, CHAR_EQUAL, CHAR_0 + 8'd2, 8'h7c, 8'h7c, DELIM_RESET,
            CHAR_1, CHAR_0, CHAR_EQUAL, CHAR_0 + 8'd7, 8'h7c};
    drain();
    write_delimiter(DELIM_RESET);
    foreach (head[i]) send_byte(head[i]);
    drain();
    write_delimiter(8'h7c);
    foreach (tail[i]) send_byte(tail[i]);
    drain();
  endtask

  // body length fields: over the capacity, non-digit, empty, then valid ones that may have leading zeros
  task automatic test_length_field();
    repeat (3) send_message(0, DEF_LEN_HUGE);
    repeat (3) send_message($urandom_range(1, 9), DEF_LEN_ALPHA);
    send_message(0, DEF_LEN_EMPTY);
    repeat (3) send_message($urandom_range(1, 30), DEF_NONE);
    drain();
  endtask

  // receiver holds off while requests keep coming, then the sender waits it out
  task automatic test_backpressure();
    long_hold_en <= 1'b1;
    repeat (4) send_message($urandom_range(2, 10), DEF_NONE);
    drain();
    long_hold_en <= 1'b0;
  endtask

  // mostly well formed messages with random content, some broken
  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned next_switch;
    stop_at     = bytes_sent + 300;
    next_switch = bytes_sent + 150;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= next_switch) begin
        drain();
        if ($urandom_range(0, 2) == 0) write_delimiter(DELIM_RESET);
        else write_delimiter(8'($urandom_range(0, 255)));
        next_switch = bytes_sent + $urandom_range(100, 200);
      end
      send_message(pick_body_len(), pick_defect());
    end
    drain();
  endtask

  // back to back requests with no idling on either side
  task automatic test_steady_stream();
    idle_on <= 1'b0;
    drain();
    write_delimiter(DELIM_RESET);
    repeat (2) send_message($urandom_range(0, 20), DEF_NONE);
    drain();
  endtask

  // main sequence
  initial begin
    cur_delim = DELIM_RESET;
    frame_restart();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_delimiter_values();
    test_write_mid_message();
    test_length_field();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes: %0d complete messages and %0d invalid frames",
             bytes_sent, ready_count, invalid_count);
    $display("%0d delimiter settings, a long receiver hold-off and a closing stretch with no idling",
             delim_settings);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
